>>> hdl/lddt_pkg.sv
// ----------------------------------------------------------------------------
// lddt_pkg: shared types and constants for the load distribution table
// Sizes, action and status codes, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lddt_pkg;

	// Table geometry
	localparam int NUM_LISTS   = 8;
	localparam int MAX_ENTRIES = 16;
	localparam int LIST_W      = $clog2(NUM_LISTS);
	localparam int SLOT_W      = $clog2(MAX_ENTRIES);
	localparam int ADDR_W      = LIST_W + SLOT_W;
	localparam int NUM_SLOTS   = NUM_LISTS * MAX_ENTRIES;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	// Field widths
	localparam int ID_W   = 16;
	localparam int LOAD_W = 16;
	localparam int TOT_W  = 20;
	localparam int CFG_W  = 4;
	localparam int ENT_W  = ID_W + LOAD_W;

	// Lists in use after reset
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(NUM_LISTS);

	typedef enum logic [1:0] {
		ACT_INSERT,
		ACT_APPEND,
		ACT_REMOVE,
		ACT_CLEAR
	} action_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_FULL,
		ST_BADPOS,
		ST_EMPTY,
		ST_BADLIST
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SHIFT,
		S_SHIFT_LAST,
		S_WRITE,
		S_REM_RD,
		S_REM_UPD,
		S_SCAN,
		S_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic check;
		logic ptr_load;
		logic shift_rd;
		logic new_wr;
		logic rem_rd;
		logic rem_upd;
		logic clear;
		logic scan_step;
		logic out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		status_t code;
		action_t act;
		logic    needs_shift;
		logic    at_pos;
		logic    scan_last;
		logic    out_busy;
	} sts_t;

endpackage

>>> hdl/lddt_ctrl.sv
// ----------------------------------------------------------------------------
// lddt_ctrl: sequencer for the load distribution table
// Steps one beat through check, entry shift or update, and the scan of
// the list totals, then hands the result to the output register.
// ----------------------------------------------------------------------------
module lddt_ctrl import lddt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (sts.code != ST_OK) begin
					state_d = S_SCAN;
				end else begin
					unique case (sts.act)
						ACT_INSERT: begin
							if (sts.needs_shift) begin
								cmd.ptr_load = 1'b1;
								state_d      = S_SHIFT;
							end else begin
								state_d = S_WRITE;
							end
						end
						ACT_APPEND: state_d = S_WRITE;
						ACT_REMOVE: state_d = S_REM_RD;
						ACT_CLEAR: begin
							cmd.clear = 1'b1;
							state_d   = S_SCAN;
						end
					endcase
				end
			end
			// one entry read per cycle, written one slot up the next cycle
			S_SHIFT: begin
				cmd.shift_rd = 1'b1;
				if (sts.at_pos) begin
					state_d = S_SHIFT_LAST;
				end
			end
			S_SHIFT_LAST: state_d = S_WRITE;
			S_WRITE: begin
				cmd.new_wr = 1'b1;
				state_d    = S_SCAN;
			end
			S_REM_RD: begin
				cmd.rem_rd = 1'b1;
				state_d    = S_REM_UPD;
			end
			S_REM_UPD: begin
				cmd.rem_upd = 1'b1;
				state_d     = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

>>> hdl/lddt_dpath.sv
// ----------------------------------------------------------------------------
// lddt_dpath: storage and arithmetic of the load distribution table
// Entry memory, per-list counts and totals, status check, least and most
// loaded scan, and the result register.
// ----------------------------------------------------------------------------
module lddt_dpath import lddt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic [1:0]        in_action,
	input  logic [LIST_W-1:0] in_sel,
	input  logic [SLOT_W-1:0] in_pos,
	input  logic [ID_W-1:0]   in_id,
	input  logic [LOAD_W-1:0] in_load,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              out_ready,
	output logic              out_valid,
	output status_t           out_status,
	output logic [ID_W-1:0]   out_rid,
	output logic [LOAD_W-1:0] out_rload,
	output logic [CNT_W-1:0]  out_cnt,
	output logic [TOT_W-1:0]  out_tot,
	output logic [LIST_W-1:0] out_least,
	output logic [LIST_W-1:0] out_most
);

	logic [CFG_W-1:0]  cfg_q;
	logic [CFG_W-1:0]  nlists;
	logic [LIST_W-1:0] last_idx;

	action_t           act_q;
	logic [LIST_W-1:0] sel_q;
	logic [SLOT_W-1:0] pos_q;
	logic [ID_W-1:0]   id_q;
	logic [LOAD_W-1:0] load_q;

	logic [CNT_W-1:0]  cnt_q [NUM_LISTS];
	logic [TOT_W-1:0]  tot_q [NUM_LISTS];
	logic [LIST_W-1:0] rd_list;
	logic [CNT_W-1:0]  cnt_cur;
	logic [TOT_W-1:0]  tot_cur;
	status_t           code;

	logic [SLOT_W-1:0] ptr_q, wptr_q;
	logic              pend_q;

	logic [ENT_W-1:0]  mem_q [NUM_SLOTS];
	logic [ENT_W-1:0]  rdata_q;
	logic              mem_re, mem_we;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic [ENT_W-1:0]  wr_data;
	logic [SLOT_W-1:0] tail_slot, new_slot;

	status_t           stat_q;
	logic [ID_W-1:0]   rid_q;
	logic [LOAD_W-1:0] rload_q;
	logic [LIST_W-1:0] scan_q, least_q, most_q;
	logic [TOT_W-1:0]  least_tot_q, most_tot_q;
	logic [CNT_W-1:0]  selcnt_q;
	logic [TOT_W-1:0]  seltot_q;

	// Lists in use register, clamped to 1..NUM_LISTS
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_data;
		end
	end

	always_comb begin
		if (cfg_q == '0) begin
			nlists = CFG_W'(1);
		end else if (cfg_q > CFG_W'(NUM_LISTS)) begin
			nlists = CFG_W'(NUM_LISTS);
		end else begin
			nlists = cfg_q;
		end
	end

	assign last_idx = LIST_W'(nlists - CFG_W'(1));

	// Beat capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q  <= action_t'(in_action);
			sel_q  <= in_sel;
			pos_q  <= in_pos;
			id_q   <= in_id;
			load_q <= in_load;
		end
	end

	// Count and total of the list being looked at
	assign rd_list = cmd.scan_step ? scan_q : sel_q;
	assign cnt_cur = cnt_q[rd_list];
	assign tot_cur = tot_q[rd_list];

	// Status check; position is checked before fullness
	always_comb begin
		code = ST_OK;
		if (CFG_W'(sel_q) >= nlists) begin
			code = ST_BADLIST;
		end else begin
			unique case (act_q)
				ACT_INSERT: begin
					if (pos_q != '0 && CNT_W'(pos_q) >= cnt_cur) begin
						code = ST_BADPOS;
					end else if (cnt_cur >= CNT_W'(MAX_ENTRIES)) begin
						code = ST_FULL;
					end
				end
				ACT_APPEND: begin
					if (cnt_cur >= CNT_W'(MAX_ENTRIES)) begin
						code = ST_FULL;
					end
				end
				ACT_REMOVE: begin
					if (cnt_cur == '0) begin
						code = ST_EMPTY;
					end
				end
				ACT_CLEAR: code = ST_OK;
			endcase
		end
	end

	// Shift pointer: reads walk down from the tail to the insert slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= cmd.shift_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ptr_load) begin
			ptr_q <= tail_slot;
		end else if (cmd.shift_rd) begin
			ptr_q  <= ptr_q - SLOT_W'(1);
			wptr_q <= ptr_q;
		end
	end

	// Entry memory ports
	assign tail_slot = SLOT_W'(cnt_cur - CNT_W'(1));
	assign new_slot  = (act_q == ACT_INSERT) ? pos_q : SLOT_W'(cnt_cur);
	assign mem_re    = cmd.shift_rd | cmd.rem_rd;
	assign rd_addr   = cmd.shift_rd ? {sel_q, ptr_q} : {sel_q, tail_slot};
	assign mem_we    = pend_q | cmd.new_wr;
	assign wr_addr   = pend_q ? {sel_q, SLOT_W'(wptr_q + SLOT_W'(1))} : {sel_q, new_slot};
	assign wr_data   = pend_q ? rdata_q : {load_q, id_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (mem_re) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	// Counts and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LISTS; i++) begin
				cnt_q[i] <= '0;
				tot_q[i] <= '0;
			end
		end else if (cmd.new_wr) begin
			cnt_q[sel_q] <= cnt_cur + CNT_W'(1);
			tot_q[sel_q] <= tot_cur + TOT_W'(load_q);
		end else if (cmd.rem_upd) begin
			cnt_q[sel_q] <= cnt_cur - CNT_W'(1);
			tot_q[sel_q] <= tot_cur - TOT_W'(rdata_q[ENT_W-1:ID_W]);
		end else if (cmd.clear) begin
			cnt_q[sel_q] <= '0;
			tot_q[sel_q] <= '0;
		end
	end

	// Status and removed entry
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			stat_q <= code;
		end
		if (cmd.capture) begin
			rid_q   <= '0;
			rload_q <= '0;
		end else if (cmd.rem_upd) begin
			rid_q   <= rdata_q[ID_W-1:0];
			rload_q <= rdata_q[ENT_W-1:ID_W];
		end
	end

	// Scan of totals, one list a cycle; lower index wins ties
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			scan_q   <= '0;
			selcnt_q <= '0;
			seltot_q <= '0;
		end else if (cmd.scan_step) begin
			if (scan_q == '0 || tot_cur < least_tot_q) begin
				least_q     <= scan_q;
				least_tot_q <= tot_cur;
			end
			if (scan_q == '0 || tot_cur > most_tot_q) begin
				most_q     <= scan_q;
				most_tot_q <= tot_cur;
			end
			if (scan_q == sel_q) begin
				selcnt_q <= cnt_cur;
				seltot_q <= tot_cur;
			end
			scan_q <= scan_q + LIST_W'(1);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status <= stat_q;
			out_rid    <= rid_q;
			out_rload  <= rload_q;
			out_cnt    <= selcnt_q;
			out_tot    <= seltot_q;
			out_least  <= least_q;
			out_most   <= most_q;
		end
	end

	assign sts.code        = code;
	assign sts.act         = act_q;
	assign sts.needs_shift = CNT_W'(pos_q) < cnt_cur;
	assign sts.at_pos      = ptr_q == pos_q;
	assign sts.scan_last   = scan_q == last_idx;
	assign sts.out_busy    = out_valid & ~out_ready;

endmodule

>>> hdl/load_distribution_table.sv
// ----------------------------------------------------------------------------
// load_distribution_table: per-list entity table with least/most loaded pick
// Stream in actions on child lists, stream out one result beat per action.
// ----------------------------------------------------------------------------
// One beat is taken at a time. The entry memory has a read port and a
// write port, and moves one entry per cycle during an insert that moves
// entries; the least and most loaded lists are found by a scan of the totals
// of the lists in use, one list per cycle. A new beat is taken as soon as the
// result has gone to the output register, even if that result is still
// waiting. Entries are only read below a list's count; the memory has no
// reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module load_distribution_table import lddt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// lists in use
	input  logic        cfg_we,
	input  logic [3:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// position[3:0], entity_id[19:4], entity_load[35:20]
	input  logic [39:0] s_axis_tdata,
	// action[1:0], list_select[4:2]
	input  logic [4:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// removed_id[15:0], removed_load[31:16], selected_count[36:32],
	// selected_total[56:37], least_loaded[59:57], most_loaded[62:60]
	output logic [63:0] m_axis_tdata,
	// status[2:0]
	output logic [2:0]  m_axis_tuser
);

	cmd_t              cmd;
	sts_t              sts;
	status_t           out_status;
	logic [ID_W-1:0]   out_rid;
	logic [LOAD_W-1:0] out_rload;
	logic [CNT_W-1:0]  out_cnt;
	logic [TOT_W-1:0]  out_tot;
	logic [LIST_W-1:0] out_least, out_most;

	lddt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lddt_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_action  (s_axis_tuser[1:0]),
		.in_sel     (s_axis_tuser[4:2]),
		.in_pos     (s_axis_tdata[3:0]),
		.in_id      (s_axis_tdata[19:4]),
		.in_load    (s_axis_tdata[35:20]),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_status (out_status),
		.out_rid    (out_rid),
		.out_rload  (out_rload),
		.out_cnt    (out_cnt),
		.out_tot    (out_tot),
		.out_least  (out_least),
		.out_most   (out_most)
	);

	// Result beat packing
	assign m_axis_tdata = {1'b0, out_most, out_least, out_tot, out_cnt, out_rload, out_rid};
	assign m_axis_tuser = out_status;

endmodule

>>> hdl/lddt_checker.sv
// ----------------------------------------------------------------------------
// lddt_checker: port-level checks for the load distribution table
// Watches the stream ports and flags handshake faults and results that the
// block can never give; bound to the top level below.
// ----------------------------------------------------------------------------
module lddt_checker import lddt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser
);

	// Stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result beat changed");

	// One beat in flight: ready drops right after a beat is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("beat taken while another is in work");

	// Only a successful action reports a removed entry
	a_removed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[31:0] == '0)
		else $error("removed entry reported on an error");

	// Bad list reports an empty count and total
	a_badlist_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_BADLIST |-> m_axis_tdata[56:32] == '0)
		else $error("bad list with nonzero count or total");

	// A list never holds more than its capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[36:32] <= CNT_W'(MAX_ENTRIES))
		else $error("count above list capacity");

endmodule

bind load_distribution_table lddt_checker u_lddt_checker (.*);

>>> sim/load_distribution_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// load_distribution_table_tb: self-checking bench for the load distribution table
// Streams action beats into the table and checks every result beat against
// a local model of the lists, their counts and load totals. The run covers
// several lists-in-use settings, bursty input, receiver stalls and one long
// output hold-off.
// ----------------------------------------------------------------------------
module load_distribution_table_tb;
	import lddt_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RAND_PER_SET = 140;
	localparam int HOLD_AT      = 370;
	localparam int HOLD_CYCLES  = 400;

	typedef struct packed {
		action_t           act;
		logic [LIST_W-1:0] sel;
		logic [SLOT_W-1:0] pos;
		logic [ID_W-1:0]   id;
		logic [LOAD_W-1:0] load;
	} table_op_t;

	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   rid;
		logic [LOAD_W-1:0] rload;
		logic [4:0]        cnt;
		logic [TOT_W-1:0]  tot;
		logic [LIST_W-1:0] least;
		logic [LIST_W-1:0] most;
	} table_result_t;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_MOSTLY,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [3:0]  cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;   // position, entity_id, entity_load
	logic [4:0]  s_axis_tuser = '0;   // action, list_select
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;        // removed id/load, count, total, least, most
	logic [2:0]  m_axis_tuser;        // status

	// Local copy of the table
	logic [ID_W-1:0]   slot_id   [NUM_LISTS][MAX_ENTRIES];
	logic [LOAD_W-1:0] slot_load [NUM_LISTS][MAX_ENTRIES];
	int                list_count [NUM_LISTS];
	int unsigned       list_sum   [NUM_LISTS];
	logic [CFG_W-1:0]  lists_cfg = CFG_RESET;

	// Stimulus side bookkeeping
	int        gen_count [NUM_LISTS];
	int        ops_queued = 0;
	table_op_t pend_ops [$];
	table_result_t expected_results [$];

	logic in_fire = 1'b0;
	logic hold_done = 1'b0;
	int   accepted_ops = 0;
	int   errors = 0;
	int   cycle_count = 0;

	load_distribution_table uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Register value 0 behaves as one list, anything above the table size as all
	function automatic int active_count(logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > NUM_LISTS)
			return NUM_LISTS;
		return int'(v);
	endfunction

	// Apply one action to the local table and return the result it yields
	function automatic table_result_t apply_table_action(table_op_t op);
		table_result_t r;
		int nl;
		int c;
		int lo;
		int hi;
		r = '0;
		r.status = ST_OK;
		nl = active_count(lists_cfg);
		if (int'(op.sel) >= nl) begin
			r.status = ST_BADLIST;
		end else begin
			c = list_count[op.sel];
			case (op.act)
				ACT_INSERT: begin
					if (op.pos != 0 && int'(op.pos) >= c) begin
						r.status = ST_BADPOS;
					end else if (c >= MAX_ENTRIES) begin
						r.status = ST_FULL;
					end else begin
						// open a gap at the slot, moving the upper entries up
						for (int i = c; i > int'(op.pos); i--) begin
							slot_id[op.sel][i]   = slot_id[op.sel][i-1];
							slot_load[op.sel][i] = slot_load[op.sel][i-1];
						end
						slot_id[op.sel][op.pos]   = op.id;
						slot_load[op.sel][op.pos] = op.load;
						list_count[op.sel] = c + 1;
						list_sum[op.sel] += op.load;
					end
				end
				ACT_APPEND: begin
					if (c >= MAX_ENTRIES) begin
						r.status = ST_FULL;
					end else begin
						slot_id[op.sel][c]   = op.id;
						slot_load[op.sel][c] = op.load;
						list_count[op.sel] = c + 1;
						list_sum[op.sel] += op.load;
					end
				end
				ACT_REMOVE: begin
					if (c == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.rid   = slot_id[op.sel][c-1];
						r.rload = slot_load[op.sel][c-1];
						list_count[op.sel] = c - 1;
						list_sum[op.sel] -= r.rload;
					end
				end
				default: begin
					list_count[op.sel] = 0;
					list_sum[op.sel] = 0;
				end
			endcase
			r.cnt = 5'(list_count[op.sel]);
			r.tot = TOT_W'(list_sum[op.sel]);
		end
		// lowest index wins ties on both picks
		lo = 0;
		hi = 0;
		for (int i = 1; i < nl; i++) begin
			if (list_sum[i] < list_sum[lo])
				lo = i;
			if (list_sum[i] > list_sum[hi])
				hi = i;
		end
		r.least = LIST_W'(lo);
		r.most  = LIST_W'(hi);
		return r;
	endfunction

	task automatic report_error(string msg);
		errors++;
		if (errors <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	// Queue one beat for the driver, tracking list counts to shape later beats
	task automatic queue_op(action_t a, int s, int p, logic [ID_W-1:0] id,
			logic [LOAD_W-1:0] load);
		table_op_t op;
		int nl;
		op.act  = a;
		op.sel  = LIST_W'(s);
		op.pos  = SLOT_W'(p);
		op.id   = id;
		op.load = load;
		nl = active_count(lists_cfg);
		if (s < nl) begin
			case (a)
				ACT_INSERT: begin
					if ((p == 0 || p < gen_count[s]) && gen_count[s] < MAX_ENTRIES)
						gen_count[s]++;
				end
				ACT_APPEND: begin
					if (gen_count[s] < MAX_ENTRIES)
						gen_count[s]++;
				end
				ACT_REMOVE: begin
					if (gen_count[s] > 0)
						gen_count[s]--;
				end
				default: gen_count[s] = 0;
			endcase
		end
		pend_ops.push_back(op);
		ops_queued++;
	endtask

	// Mostly random values, with the extremes now and then
	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// A legal action on one list: inserts aim at a valid slot
	task automatic queue_legal(int l);
		int r;
		int p;
		r = $urandom_range(0, 99);
		p = (gen_count[l] == 0) ? 0 : $urandom_range(0, gen_count[l] - 1);
		if (r < 35)
			queue_op(ACT_INSERT, l, p, pick16(), pick16());
		else if (r < 70)
			queue_op(ACT_APPEND, l, p, pick16(), pick16());
		else if (r < 95)
			queue_op(ACT_REMOVE, l, p, pick16(), pick16());
		else
			queue_op(ACT_CLEAR, l, p, pick16(), pick16());
	endtask

	// Random part of one setting: fills, drains, legal mixes and some noise
	task automatic queue_random(int n);
		int target;
		int nl;
		int kind;
		int l;
		int len;
		target = ops_queued + n;
		nl = active_count(lists_cfg);
		while (ops_queued < target) begin
			kind = $urandom_range(0, 9);
			l = $urandom_range(0, nl - 1);
			if (kind < 2) begin
				// fill to the top, then one more to hit the full case
				while (gen_count[l] < MAX_ENTRIES) begin
					if ($urandom_range(0, 1))
						queue_op(ACT_APPEND, l, $urandom_range(0, 15), pick16(), pick16());
					else
						queue_op(ACT_INSERT, l,
							gen_count[l] == 0 ? 0 : $urandom_range(0, gen_count[l] - 1),
							pick16(), pick16());
				end
				queue_op($urandom_range(0, 1) ? ACT_APPEND : ACT_INSERT, l,
					$urandom_range(0, 15), pick16(), pick16());
			end else if (kind < 4) begin
				// drain past empty
				while (gen_count[l] > 0)
					queue_op(ACT_REMOVE, l, $urandom_range(0, 15), pick16(), pick16());
				queue_op(ACT_REMOVE, l, $urandom_range(0, 15), pick16(), pick16());
			end else if (kind < 9) begin
				len = $urandom_range(4, 16);
				repeat (len)
					queue_legal(l);
			end else begin
				len = $urandom_range(1, 4);
				repeat (len)
					queue_op(action_t'($urandom_range(0, 3)), $urandom_range(0, 7),
						$urandom_range(0, 15), pick16(), pick16());
			end
		end
	endtask

	// Hold until every queued beat is in and every result is out
	task automatic wait_drained();
		while (pend_ops.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Input driver: bursts of random length separated by random gaps
	always @(negedge clk) begin : input_driver
		table_op_t op;
		logic      nxt_valid;
		int        burst_left;
		int        gap_left;
		nxt_valid = s_axis_tvalid && !in_fire;
		if (!nxt_valid) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pend_ops.size() != 0) begin
				op = pend_ops.pop_front();
				s_axis_tdata <= {4'd0, op.load, op.id, op.pos};
				s_axis_tuser <= {op.sel, op.act};
				nxt_valid = 1'b1;
				if (burst_left <= 0)
					burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 12);
				burst_left--;
				if (burst_left == 0)
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end
		end
		s_axis_tvalid <= nxt_valid;
	end

	// Output receiver: changing stall modes plus one long hold-off
	always @(negedge clk) begin : output_receiver
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		logic     rdy;
		int       tick;
		tick++;
		if (!hold_done && accepted_ops >= HOLD_AT) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else begin
			if (mode_left <= 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			case (mode)
				RX_FREE:   rdy = 1'b1;
				RX_MOSTLY: rdy = ($urandom_range(0, 3) != 0);
				RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
				default:   rdy = (tick % 7) < 3;
			endcase
		end
		m_axis_tready <= rdy;
	end

	// Monitor: predict on each input beat, check each result beat
	always @(posedge clk) begin : monitor
		table_op_t     op;
		table_result_t got;
		table_result_t want;
		in_fire <= s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			op.act  = action_t'(s_axis_tuser[1:0]);
			op.sel  = s_axis_tuser[4:2];
			op.pos  = s_axis_tdata[3:0];
			op.id   = s_axis_tdata[19:4];
			op.load = s_axis_tdata[35:20];
			expected_results.push_back(apply_table_action(op));
			accepted_ops++;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = status_t'(m_axis_tuser);
			got.rid    = m_axis_tdata[15:0];
			got.rload  = m_axis_tdata[31:16];
			got.cnt    = m_axis_tdata[36:32];
			got.tot    = m_axis_tdata[56:37];
			got.least  = m_axis_tdata[59:57];
			got.most   = m_axis_tdata[62:60];
			if (expected_results.size() == 0) begin
				report_error($sformatf("result beat with none outstanding: st=%0d data=%h",
					m_axis_tuser, m_axis_tdata));
			end else begin
				want = expected_results.pop_front();
				if (got.status != want.status || got.rid != want.rid ||
						got.rload != want.rload || got.cnt != want.cnt ||
						got.tot != want.tot || got.least != want.least ||
						got.most != want.most)
					report_error($sformatf({"mismatch: exp st=%0d id=%h ld=%h cnt=%0d ",
						"tot=%h lo=%0d hi=%0d / got st=%0d id=%h ld=%h cnt=%0d tot=%h ",
						"lo=%0d hi=%0d"},
						want.status, want.rid, want.rload, want.cnt, want.tot, want.least,
						want.most, got.status, got.rid, got.rload, got.cnt, got.tot,
						got.least, got.most));
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// Sequence: reset, directed beats, then random beats under each setting
	initial begin
		logic [CFG_W-1:0] settings [11];
		settings = '{4'd15, 4'd0, 4'd3, 4'd1, 4'd9, 4'd5, 4'd8, 4'd2, 4'd7, 4'd4, 4'd6};
		for (int i = 0; i < NUM_LISTS; i++) begin
			list_count[i] = 0;
			list_sum[i] = 0;
			gen_count[i] = 0;
		end
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part, with the reset setting of all lists in use
		queue_op(ACT_REMOVE, 0, 0, 16'h0000, 16'h0000);   // empty list
		queue_op(ACT_INSERT, 0, 0, 16'hFFFF, 16'hFFFF);   // slot 0 of an empty list
		queue_op(ACT_INSERT, 0, 1, 16'h1111, 16'h0001);   // slot at the count
		queue_op(ACT_INSERT, 0, 0, 16'h0000, 16'h0000);   // moves one entry
		queue_op(ACT_INSERT, 0, 1, 16'h00AA, 16'h1234);   // middle slot
		queue_op(ACT_APPEND, 0, 0, 16'h5555, 16'hAAAA);
		queue_op(ACT_INSERT, 0, 15, 16'h7777, 16'h7777);  // slot far above the count
		queue_op(ACT_REMOVE, 0, 0, 16'h0000, 16'h0000);
		for (int k = 0; k < MAX_ENTRIES; k++)
			queue_op(ACT_APPEND, 7, k, 16'(k * 4099), 16'(16'hFFFF - k));
		queue_op(ACT_INSERT, 7, 5, 16'h2222, 16'h0002);   // full, slot in range
		queue_op(ACT_APPEND, 7, 0, 16'h3333, 16'h0003);   // full
		queue_op(ACT_CLEAR, 0, 0, 16'h0000, 16'h0000);
		wait_drained();

		foreach (settings[s]) begin
			cfg_we   <= 1'b1;
			cfg_data <= settings[s];
			lists_cfg = settings[s];
			@(negedge clk);
			cfg_we <= 1'b0;
			@(negedge clk);
			queue_random(RAND_PER_SET);
			wait_drained();
		end

		if (expected_results.size() != 0)
			report_error($sformatf("%0d results never arrived", expected_results.size()));
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
